// ===== hdl/gsa_pkg.sv =====
// Package for the generational slot allocator: sizes, codes and shared types.
`default_nettype none
package gsa_pkg;

    localparam int SLOT_CAPACITY = 1024;
    localparam int SLOT_AW       = $clog2(SLOT_CAPACITY);
    localparam int CNT_W         = $clog2(SLOT_CAPACITY + 1);

    localparam int IDX_W         = 10;
    localparam int GEN_W         = 32;
    localparam int WORD_W        = 32;
    localparam int LIVE_W        = 11;
    localparam int BOUND_WORDS   = 4;
    localparam int TMPL_WORDS    = 5;
    localparam int BOUND_W       = BOUND_WORDS * WORD_W;
    localparam int TMPL_W        = TMPL_WORDS * WORD_W;

    typedef enum logic [1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_UNREGISTER = 2'd1,
        MODE_BOUNDS     = 2'd2,
        MODE_TEMPLATE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HANDLE = 2'd1,
        ST_FULL       = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_POP
    } t_state;

    typedef struct packed {
        logic             live;
        logic [GEN_W-1:0] gen;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef struct packed {
        logic               meta_we;
        logic [SLOT_AW-1:0] meta_waddr;
        t_meta              meta_wdata;
        logic [SLOT_AW-1:0] meta_raddr;
        logic               stack_we;
        logic [SLOT_AW-1:0] stack_waddr;
        logic [SLOT_AW-1:0] stack_wdata;
        logic [SLOT_AW-1:0] stack_raddr;
        logic               bounds_we;
        logic               tmpl_we;
        logic [SLOT_AW-1:0] store_addr;
        logic [BOUND_W-1:0] bounds_wdata;
        logic [TMPL_W-1:0]  tmpl_wdata;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== hdl/gsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/gsa_store.sv =====
// Per-slot bounding-sphere and draw-template word stores.
`default_nettype none
module gsa_store
    import gsa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req
);

    logic [BOUND_W-1:0] bounds_mem [SLOT_CAPACITY];
    logic [TMPL_W-1:0]  tmpl_mem   [SLOT_CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.bounds_we) begin
            bounds_mem[i_req.store_addr] <= i_req.bounds_wdata;
        end
        if (i_req.tmpl_we) begin
            tmpl_mem[i_req.store_addr] <= i_req.tmpl_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gsa_ctrl.sv =====
// Sequencer: handle check, free-stack pop/push, counters and result word.
`default_nettype none
module gsa_ctrl
    import gsa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_mode,
    input  wire logic [IDX_W-1:0]    i_slot_index,
    input  wire logic [GEN_W-1:0]    i_slot_generation,
    input  wire logic [BOUND_W-1:0]  i_bounds,
    input  wire logic [TMPL_W-1:0]   i_tmpl,
    input  wire t_meta               i_meta_rdata,
    input  wire logic [SLOT_AW-1:0]  i_stack_rdata,
    output t_mem_req                 o_req,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic [IDX_W-1:0]         o_handle_index,
    output logic [GEN_W-1:0]         o_handle_generation,
    output logic [LIVE_W-1:0]        o_live_total
);

    t_state             r_state, n_state;
    t_mode              r_mode;
    logic [IDX_W-1:0]   r_idx;
    logic [GEN_W-1:0]   r_gen;
    logic [BOUND_W-1:0] r_bounds;
    logic [TMPL_W-1:0]  r_tmpl;
    logic [SLOT_AW-1:0] r_pop_slot, n_pop_slot;
    logic [CNT_W-1:0]   r_live, n_live;
    logic [CNT_W-1:0]   r_free, n_free;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_hidx, n_hidx;
    logic [GEN_W-1:0]   r_hgen, n_hgen;

    logic               accept;
    logic               in_range;
    logic               ever_used;
    logic               handle_ok;
    logic [SLOT_AW-1:0] slot_a;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign slot_a    = SLOT_AW'(r_idx);
    assign in_range  = 32'(r_idx) < 32'(SLOT_CAPACITY);
    // slots at or above live + free have never been handed out, so their
    // live bit in memory is unwritten and counts as clear
    assign ever_used = 32'(r_idx) < (32'(r_live) + 32'(r_free));
    assign handle_ok = in_range && ever_used && i_meta_rdata.live
                    && (i_meta_rdata.gen == r_gen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_free  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_free  <= n_free;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= t_mode'(i_mode);
            r_idx    <= i_slot_index;
            r_gen    <= i_slot_generation;
            r_bounds <= i_bounds;
            r_tmpl   <= i_tmpl;
        end
        r_pop_slot <= n_pop_slot;
        r_status   <= n_status;
        r_hidx     <= n_hidx;
        r_hgen     <= n_hgen;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_mode == MODE_REGISTER && r_free != '0) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req              = '0;
        o_req.meta_raddr   = SLOT_AW'(i_slot_index);
        o_req.stack_raddr  = SLOT_AW'(r_free - CNT_W'(1));
        o_req.stack_waddr  = SLOT_AW'(r_free);
        o_req.stack_wdata  = slot_a;
        o_req.store_addr   = slot_a;
        o_req.meta_waddr   = slot_a;
        o_req.bounds_wdata = r_bounds;
        o_req.tmpl_wdata   = r_tmpl;
        n_pop_slot = r_pop_slot;
        n_live     = r_live;
        n_free     = r_free;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_hidx     = r_hidx;
        n_hgen     = r_hgen;

        unique case (r_state)
            S_IDLE: begin
            end
            S_LOOK: begin
                if (r_mode == MODE_REGISTER) begin
                    priority if (r_free != '0) begin
                        // pop: generation of the popped slot is read next
                        n_pop_slot       = i_stack_rdata;
                        o_req.meta_raddr = i_stack_rdata;
                    end else if (32'(r_live) < 32'(SLOT_CAPACITY)) begin
                        o_req.meta_we         = 1'b1;
                        o_req.meta_waddr      = SLOT_AW'(r_live);
                        o_req.meta_wdata.live = 1'b1;
                        o_req.meta_wdata.gen  = '0;
                        o_req.bounds_we       = 1'b1;
                        o_req.tmpl_we         = 1'b1;
                        o_req.store_addr      = SLOT_AW'(r_live);
                        n_live   = r_live + CNT_W'(1);
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_hidx   = IDX_W'(r_live);
                        n_hgen   = '0;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ST_FULL;
                        n_hidx   = '0;
                        n_hgen   = '0;
                    end
                end else begin
                    n_valid = 1'b1;
                    n_hidx  = r_idx;
                    n_hgen  = r_gen;
                    if (!handle_ok) begin
                        n_status = ST_BAD_HANDLE;
                    end else begin
                        n_status = ST_OK;
                        unique case (r_mode)
                            MODE_UNREGISTER: begin
                                o_req.meta_we         = 1'b1;
                                o_req.meta_wdata.live = 1'b0;
                                o_req.meta_wdata.gen  = i_meta_rdata.gen + GEN_W'(1);
                                o_req.stack_we        = 1'b1;
                                n_free = r_free + CNT_W'(1);
                                n_live = r_live - CNT_W'(1);
                            end
                            MODE_BOUNDS:   o_req.bounds_we = 1'b1;
                            MODE_TEMPLATE: o_req.tmpl_we   = 1'b1;
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_POP: begin
                o_req.meta_we         = 1'b1;
                o_req.meta_waddr      = r_pop_slot;
                o_req.meta_wdata.live = 1'b1;
                o_req.meta_wdata.gen  = i_meta_rdata.gen;
                o_req.bounds_we       = 1'b1;
                o_req.tmpl_we         = 1'b1;
                o_req.store_addr      = r_pop_slot;
                n_free   = r_free - CNT_W'(1);
                n_live   = r_live + CNT_W'(1);
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_hidx   = IDX_W'(r_pop_slot);
                n_hgen   = i_meta_rdata.gen;
            end
            default: begin
            end
        endcase
    end

    assign o_valid             = r_valid;
    assign o_status            = r_status;
    assign o_handle_index      = r_hidx;
    assign o_handle_generation = r_hgen;
    assign o_live_total        = LIVE_W'(r_live);

endmodule
`default_nettype wire

// ===== hdl/generational_slot_allocator.sv =====
// Top level of the generational slot allocator.
//
// Command channel: a word is taken at a rising edge with start high and busy
// low. mode selects register, unregister, update bounds or set template.
// Result channel: o_valid is high for exactly one cycle with o_status,
// o_handle_index, o_handle_generation and o_live_total; the receiver cannot
// hold it off, and busy falls in the same cycle, so the next word may be
// taken at the edge that ends the strobe.
// From acceptance a word passes the look state on to the strobe; a register
// that pops a freed index passes the pop state too (free-stack read, then the
// popped slot's generation read from the slot memory). No new word is taken
// until the strobe ends; the registered read data of the slot memory sets this.
// Reset (synchronous, active low) clears the live and free counts; no memory
// clearing pass runs. Slots at or above live + free were never handed out and
// read as not live, so the block accepts words right after reset.
`default_nettype none
module generational_slot_allocator
    import gsa_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_mode,
    input  wire logic [IDX_W-1:0]         i_slot_index,
    input  wire logic [GEN_W-1:0]         i_slot_generation,
    input  wire logic [WORD_W-1:0]        i_bound_center_x,
    input  wire logic [WORD_W-1:0]        i_bound_center_y,
    input  wire logic [WORD_W-1:0]        i_bound_center_z,
    input  wire logic [WORD_W-1:0]        i_bound_radius,
    input  wire logic [WORD_W-1:0]        i_draw_index_count,
    input  wire logic [WORD_W-1:0]        i_draw_instance_count,
    input  wire logic [WORD_W-1:0]        i_draw_first_index,
    input  wire logic signed [WORD_W-1:0] i_draw_vertex_offset,
    input  wire logic [WORD_W-1:0]        i_draw_first_instance,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [IDX_W-1:0]              o_handle_index,
    output logic [GEN_W-1:0]              o_handle_generation,
    output logic [LIVE_W-1:0]             o_live_total
);

    t_mem_req           req;
    t_meta              meta_rdata;
    logic [SLOT_AW-1:0] stack_rdata;
    logic [BOUND_W-1:0] bounds;
    logic [TMPL_W-1:0]  tmpl;

    assign bounds = {i_bound_radius, i_bound_center_z, i_bound_center_y, i_bound_center_x};
    assign tmpl   = {i_draw_first_instance, $unsigned(i_draw_vertex_offset),
                     i_draw_first_index, i_draw_instance_count, i_draw_index_count};

    gsa_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_mode              (i_mode),
        .i_slot_index        (i_slot_index),
        .i_slot_generation   (i_slot_generation),
        .i_bounds            (bounds),
        .i_tmpl              (tmpl),
        .i_meta_rdata        (meta_rdata),
        .i_stack_rdata       (stack_rdata),
        .o_req               (req),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_handle_index      (o_handle_index),
        .o_handle_generation (o_handle_generation),
        .o_live_total        (o_live_total)
    );

    // live bit and generation of each slot
    gsa_ram #(
        .WIDTH (META_W),
        .DEPTH (SLOT_CAPACITY)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (req.meta_we),
        .i_waddr (req.meta_waddr),
        .i_wdata (req.meta_wdata),
        .i_raddr (req.meta_raddr),
        .o_rdata (meta_rdata)
    );

    // LIFO of freed slot indices
    gsa_ram #(
        .WIDTH (SLOT_AW),
        .DEPTH (SLOT_CAPACITY)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (req.stack_we),
        .i_waddr (req.stack_waddr),
        .i_wdata (req.stack_wdata),
        .i_raddr (req.stack_raddr),
        .o_rdata (stack_rdata)
    );

    gsa_store u_store (
        .i_clk (i_clk),
        .i_req (req)
    );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the generational slot allocator.
`timescale 1ns / 100ps
module testbench
    import gsa_pkg::*;
();

    localparam int RANDOM_WORDS   = 1625;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        t_mode                      mode;
        logic [IDX_W-1:0]           idx;
        logic [GEN_W-1:0]           gen;
        logic [8:0][WORD_W-1:0]     pay;    // 4 bound words, then 5 template words
    } t_word;

    typedef struct packed {
        t_status          st;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        logic [LIVE_W-1:0] live;
    } t_res;

    typedef struct packed {
        t_word w;
        logic  fixed;
        t_res  res;
    } t_dir_row;

    typedef enum {FILL_RAND, FILL_ONES, FILL_ZERO, FILL_VOFF_MIN, FILL_VOFF_MAX} t_fill;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_word             cur_word = '0;
    logic              cur_fixed = 1'b0;
    t_res              cur_fixed_res = '0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [IDX_W-1:0]  o_handle_index;
    logic [GEN_W-1:0]  o_handle_generation;
    logic [LIVE_W-1:0] o_live_total;

    // slot table as the block should see it
    bit               live_bits [SLOT_CAPACITY];
    logic [GEN_W-1:0] gen_tbl   [SLOT_CAPACITY];
    int               free_lifo [SLOT_CAPACITY];
    int               free_cnt;
    int               live_cnt;

    t_res     answers_due[$];
    t_dir_row dir_rows[$];
    logic     word_taken = 1'b0;
    int       idle_cycles = 0;
    int       n_errors = 0, n_words = 0, n_results = 0, n_random = 0;
    int       n_full = 0, n_bad = 0, peak_live = 0, peak_free = 0;
    int       gap_count = 0;
    logic     gappy = 1'b1;

    always #5 i_clk = ~i_clk;

    generational_slot_allocator dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_mode                (cur_word.mode),
        .i_slot_index          (cur_word.idx),
        .i_slot_generation     (cur_word.gen),
        .i_bound_center_x      (cur_word.pay[0]),
        .i_bound_center_y      (cur_word.pay[1]),
        .i_bound_center_z      (cur_word.pay[2]),
        .i_bound_radius        (cur_word.pay[3]),
        .i_draw_index_count    (cur_word.pay[4]),
        .i_draw_instance_count (cur_word.pay[5]),
        .i_draw_first_index    (cur_word.pay[6]),
        .i_draw_vertex_offset  (cur_word.pay[7]),
        .i_draw_first_instance (cur_word.pay[8]),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_handle_index        (o_handle_index),
        .o_handle_generation   (o_handle_generation),
        .o_live_total          (o_live_total)
    );

    function automatic t_res predict_slot_op(input t_word w);
        t_res r;
        int   s;
        r.st  = ST_OK;
        r.idx = w.idx;
        r.gen = w.gen;
        s     = int'(w.idx);
        if (w.mode == MODE_REGISTER) begin
            if (free_cnt > 0) begin
                free_cnt--;
                s = free_lifo[free_cnt];
            end else if (live_cnt < SLOT_CAPACITY) begin
                s = live_cnt;
                gen_tbl[s] = '0;
            end else begin
                s = -1;
            end
            if (s < 0) begin
                r.st  = ST_FULL;
                r.idx = '0;
                r.gen = '0;
                n_full++;
            end else begin
                live_bits[s] = 1'b1;
                live_cnt++;
                r.idx = s[IDX_W-1:0];
                r.gen = gen_tbl[s];
            end
        end else if (s >= SLOT_CAPACITY || !live_bits[s] || gen_tbl[s] != w.gen) begin
            r.st = ST_BAD_HANDLE;
            n_bad++;
        end else if (w.mode == MODE_UNREGISTER) begin
            live_bits[s] = 1'b0;
            gen_tbl[s]   = gen_tbl[s] + 1'b1;
            if (free_cnt < SLOT_CAPACITY) begin
                free_lifo[free_cnt] = s;
                free_cnt++;
            end
            if (live_cnt > 0) live_cnt--;
        end
        // bound and template words never reach the outputs
        r.live = live_cnt[LIVE_W-1:0];
        if (live_cnt > peak_live) peak_live = live_cnt;
        if (free_cnt > peak_free) peak_free = free_cnt;
        return r;
    endfunction

    function automatic void check_result(input t_res want, input t_res got);
        if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            n_errors++;
        end
        if (got.idx !== want.idx) begin
            $error("handle_index: expected %0d, got %0d", want.idx, got.idx);
            n_errors++;
        end
        if (got.gen !== want.gen) begin
            $error("handle_generation: expected %h, got %h", want.gen, got.gen);
            n_errors++;
        end
        if (got.live !== want.live) begin
            $error("live_total: expected %0d, got %0d", want.live, got.live);
            n_errors++;
        end
    endfunction

    function automatic void queue_answer(input t_res want);
        answers_due.insert(answers_due.size(), want);
    endfunction

    function automatic void add_row(input t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // results are checked before the new word is predicted: a strobe in the
    // same cycle belongs to the earlier word
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                got.st   = t_status'(o_status);
                got.idx  = o_handle_index;
                got.gen  = o_handle_generation;
                got.live = o_live_total;
                n_results++;
                if (answers_due.size() == 0) begin
                    $error("result with nothing outstanding: status %0d index %0d",
                           got.st, got.idx);
                    n_errors++;
                end else begin
                    check_result(answers_due.pop_front(), got);
                end
            end
            if (start && busy === 1'b0) begin
                word_taken = 1'b1;
                want = predict_slot_op(cur_word);
                if (cur_fixed) want = cur_fixed_res;
                queue_answer(want);
                n_words++;
            end
        end
        if (word_taken || o_valid === 1'b1) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: %0d cycles without a handshake", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // alternate stretches of random gaps with back-to-back words
    function automatic int next_gap();
        gap_count++;
        if (gap_count % 40 == 0) gappy = ~gappy;
        return gappy ? $urandom_range(0, 8) : 0;
    endfunction

    function automatic t_dir_row mk_row(t_mode m, int idx, logic [GEN_W-1:0] gen, t_fill f,
                                        logic fixed, t_status st, int ridx,
                                        logic [GEN_W-1:0] rgen, int rlive);
        t_dir_row row;
        row.w.mode = m;
        row.w.idx  = idx[IDX_W-1:0];
        row.w.gen  = gen;
        foreach (row.w.pay[k]) begin
            case (f)
                FILL_ONES: row.w.pay[k] = '1;
                FILL_ZERO: row.w.pay[k] = '0;
                default:   row.w.pay[k] = $urandom;
            endcase
        end
        if (f == FILL_VOFF_MIN) row.w.pay[7] = 32'h8000_0000;
        if (f == FILL_VOFF_MAX) row.w.pay[7] = 32'h7fff_ffff;
        row.fixed    = fixed;
        row.res.st   = st;
        row.res.idx  = ridx[IDX_W-1:0];
        row.res.gen  = rgen;
        row.res.live = rlive[LIVE_W-1:0];
        return row;
    endfunction

    // issued slots are exactly 0 .. live + free - 1
    function automatic int pick_live_slot();
        int hwm;
        int first;
        int j;
        hwm = live_cnt + free_cnt;
        if (live_cnt == 0 || hwm == 0) return -1;
        first = $urandom_range(0, hwm - 1);
        for (int k = 0; k < hwm; k++) begin
            j = (first + k) % hwm;
            if (live_bits[j]) return j;
        end
        return -1;
    endfunction

    function automatic t_word make_random_word(int reg_pct, int noise_pct, int unreg_pct);
        t_word w;
        int    r;
        int    s;
        int    hwm;
        foreach (w.pay[k]) begin
            case ($urandom_range(0, 15))
                0:       w.pay[k] = '1;
                1:       w.pay[k] = '0;
                default: w.pay[k] = $urandom;
            endcase
        end
        w.idx = IDX_W'($urandom);
        w.gen = $urandom;
        hwm   = live_cnt + free_cnt;
        r     = $urandom_range(0, 99);
        if (r < reg_pct) begin
            w.mode = MODE_REGISTER;
        end else if (r < reg_pct + noise_pct || live_cnt == 0) begin
            // stale, future or random generations, mostly on issued slots
            w.mode = t_mode'($urandom_range(1, 3));
            if (hwm > 0) begin
                case ($urandom_range(0, 3))
                    1: begin
                        s = $urandom_range(0, hwm - 1);
                        w.idx = s[IDX_W-1:0];
                        w.gen = gen_tbl[s] - 1'b1;
                    end
                    2: begin
                        s = $urandom_range(0, hwm - 1);
                        w.idx = s[IDX_W-1:0];
                        w.gen = gen_tbl[s] + 1'b1;
                    end
                    3: begin
                        s = pick_live_slot();
                        if (s >= 0) w.idx = s[IDX_W-1:0];
                    end
                    default: ;
                endcase
            end
        end else begin
            s = pick_live_slot();
            w.idx = s[IDX_W-1:0];
            w.gen = gen_tbl[s];
            if ($urandom_range(0, 99) < unreg_pct) w.mode = MODE_UNREGISTER;
            else w.mode = $urandom_range(0, 1) ? MODE_BOUNDS : MODE_TEMPLATE;
        end
        return w;
    endfunction

    // called just after a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input t_word w, input logic fixed, input t_res fr, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_word      <= w;
        cur_fixed     <= fixed;
        cur_fixed_res <= fr;
        start         <= 1'b1;
        do @(negedge i_clk); while (!word_taken);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (answers_due.size() != 0);
    endtask

    task automatic send_random(input int reg_pct, input int noise_pct, input int unreg_pct);
        send_word(make_random_word(reg_pct, noise_pct, unreg_pct), 1'b0, '0, next_gap());
        n_random++;
    endtask

    initial begin
        foreach (live_bits[k]) begin
            live_bits[k] = 1'b0;
            gen_tbl[k]   = '0;
            free_lifo[k] = 0;
        end
        free_cnt = 0;
        live_cnt = 0;

        // empty table: every handle is bad
        add_row(mk_row(MODE_UNREGISTER, 0, 0, FILL_RAND, 1, ST_BAD_HANDLE, 0, 0, 0));
        add_row(mk_row(MODE_BOUNDS, 1023, '1, FILL_ONES, 1, ST_BAD_HANDLE,
                       1023, '1, 0));
        add_row(mk_row(MODE_TEMPLATE, 5, 0, FILL_ZERO, 1, ST_BAD_HANDLE, 5, 0, 0));
        // fresh slots, handle fields ignored
        add_row(mk_row(MODE_REGISTER, 1023, '1, FILL_ONES, 1, ST_OK, 0, 0, 1));
        add_row(mk_row(MODE_REGISTER, 0, 0, FILL_ZERO, 1, ST_OK, 1, 0, 2));
        add_row(mk_row(MODE_REGISTER, 0, 0, FILL_RAND, 1, ST_OK, 2, 0, 3));
        add_row(mk_row(MODE_BOUNDS, 0, 0, FILL_ONES, 1, ST_OK, 0, 0, 3));
        add_row(mk_row(MODE_TEMPLATE, 1, 0, FILL_VOFF_MIN, 1, ST_OK, 1, 0, 3));
        add_row(mk_row(MODE_TEMPLATE, 2, 0, FILL_VOFF_MAX, 1, ST_OK, 2, 0, 3));
        // generation mismatch on a live slot, then a good free of it
        add_row(mk_row(MODE_BOUNDS, 1, 1, FILL_RAND, 1, ST_BAD_HANDLE, 1, 1, 3));
        add_row(mk_row(MODE_UNREGISTER, 1, 0, FILL_RAND, 1, ST_OK, 1, 0, 2));
        // double free, then the new generation on a dead slot
        add_row(mk_row(MODE_UNREGISTER, 1, 0, FILL_RAND, 1, ST_BAD_HANDLE, 1, 0, 2));
        add_row(mk_row(MODE_BOUNDS, 1, 1, FILL_RAND, 1, ST_BAD_HANDLE, 1, 1, 2));
        add_row(mk_row(MODE_REGISTER, 0, 0, FILL_RAND, 1, ST_OK, 1, 1, 3));
        // LIFO order of the free stack, then a fresh slot once it is empty
        add_row(mk_row(MODE_UNREGISTER, 0, 0, FILL_RAND, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_UNREGISTER, 2, 0, FILL_RAND, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_REGISTER, 0, 0, FILL_RAND, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_REGISTER, 0, 0, FILL_ZERO, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_REGISTER, 0, 0, FILL_ONES, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_TEMPLATE, 3, 0, FILL_ONES, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_UNREGISTER, 3, 0, FILL_ZERO, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_REGISTER, 0, 0, FILL_RAND, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_UNREGISTER, 3, 1, FILL_RAND, 0, ST_OK, 0, 0, 0));
        add_row(mk_row(MODE_BOUNDS, 3, 2, FILL_RAND, 0, ST_OK, 0, 0, 0));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_word(dir_rows[k].w, dir_rows[k].fixed, dir_rows[k].res,
                                        next_gap());
        wait_drained();

        repeat (350) send_random(45, 10, 50);
        wait_drained();

        // fill the table, then knock on it while full
        while (live_cnt < SLOT_CAPACITY && n_random < RANDOM_WORDS) send_random(92, 3, 30);
        repeat (24) send_random(60, 20, 0);
        wait_drained();

        while (n_random < RANDOM_WORDS) send_random(15, 10, 70);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Words: %0d, results: %0d, table full: %0d, bad handle: %0d",
                 n_words, n_results, n_full, n_bad);
        $display("Peak live slots: %0d, deepest free stack: %0d", peak_live, peak_free);
        if (n_errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gsa_pkg.sv
hdl/gsa_ram.sv
hdl/gsa_store.sv
hdl/gsa_ctrl.sv
hdl/generational_slot_allocator.sv
bench/testbench.sv
